@@ hw/rtl/gnue_pkg.sv @@
// Shared types, constants and helper functions of the Gaussian noise update engine.
`timescale 1ns / 1ps

package gnue_pkg;

  // Input item as it travels on the input channel.
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value_in;
    logic signed [31:0] state_in;
    logic               last_in;
  } in_item_t;

  // Result item as it travels on the output channel.
  typedef struct packed {
    logic signed [31:0] value_out;
    logic signed [31:0] state_out;
    logic [31:0]        uniform_raw;
    logic               last_out;
  } out_item_t;

  // Configuration register contents handed from the register file to the core.
  typedef struct packed {
    logic [63:0]        init_state;
    logic [63:0]        init_seq;
    logic signed [31:0] mean_level;
    logic signed [31:0] white_gain;
    logic [16:0]        decay_factor;
    logic signed [31:0] noise_variance;
    logic signed [31:0] state_scale;
  } cfg_t;

  // Action codes.
  localparam logic [2:0] ACT_RESEED   = 3'd0;
  localparam logic [2:0] ACT_UNIFORM  = 3'd1;
  localparam logic [2:0] ACT_NORMAL   = 3'd2;
  localparam logic [2:0] ACT_WHITE    = 3'd3;
  localparam logic [2:0] ACT_TEMPORAL = 3'd4;
  localparam logic [2:0] ACT_REVERT   = 3'd5;

  // Register indexes.
  localparam logic [2:0] REG_INIT_STATE     = 3'd0;
  localparam logic [2:0] REG_INIT_SEQ       = 3'd1;
  localparam logic [2:0] REG_MEAN_LEVEL     = 3'd2;
  localparam logic [2:0] REG_WHITE_GAIN     = 3'd3;
  localparam logic [2:0] REG_DECAY_FACTOR   = 3'd4;
  localparam logic [2:0] REG_NOISE_VARIANCE = 3'd5;
  localparam logic [2:0] REG_STATE_SCALE    = 3'd6;

  localparam logic [16:0] DECAY_RESET = 17'd65536;

  localparam logic [63:0]        PCG_MULT     = 64'd6364136223846793005;
  localparam logic [31:0]        LN2_Q32      = 32'd2977044472;
  localparam logic [29:0]        T_CLAMP      = 30'd668792462;
  localparam logic [31:0]        HALFPI_Q30   = 32'd1686629713;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

  localparam int LOG_STEPS    = 24;
  localparam int SQRT_STEPS   = 20;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [37:0] SAMPLE_MAX = 38'sd1048575;
  localparam logic signed [37:0] SAMPLE_MIN = -38'sd1048576;

  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  // XSH-RR output permutation of the generator state before its step.
  function automatic logic [31:0] pcg_out(input logic [63:0] old);
    logic [63:0] mix;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [4:0]  rot_n;
    mix   = ((old >> 18) ^ old) >> 27;
    xs    = mix[31:0];
    rot   = old[63:59];
    rot_n = 5'd0 - rot;
    return (xs >> rot) | (xs << rot_n);
  endfunction

  // Rotation angle of CORDIC step i in Q2.30 radians.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    unique case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      default: a = 34'sd1 <<< (5'd30 - i);
    endcase
    return a;
  endfunction

  function automatic logic signed [20:0] clamp21(input logic signed [37:0] v);
    logic signed [37:0] c;
    if (v > SAMPLE_MAX) begin
      c = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      c = SAMPLE_MIN;
    end else begin
      c = v;
    end
    return c[20:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] c;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

endpackage

@@ hw/rtl/gnue_mult.sv @@
// Shared signed 34 x 34 multiplier with a registered product.
`timescale 1ns / 1ps

module gnue_mult (
  input  logic               clk,
  input  logic signed [33:0] mul_a,
  input  logic signed [33:0] mul_b,
  output logic signed [67:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

@@ hw/rtl/gnue_cfg.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module gnue_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output gnue_pkg::cfg_t       cfg
);

  gnue_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_state     <= '0;
      cfg_r.init_seq       <= '0;
      cfg_r.mean_level     <= '0;
      cfg_r.white_gain     <= '0;
      cfg_r.decay_factor   <= gnue_pkg::DECAY_RESET;
      cfg_r.noise_variance <= '0;
      cfg_r.state_scale    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        gnue_pkg::REG_INIT_STATE:     cfg_r.init_state     <= pwdata;
        gnue_pkg::REG_INIT_SEQ:       cfg_r.init_seq       <= pwdata;
        gnue_pkg::REG_MEAN_LEVEL:     cfg_r.mean_level     <= pwdata[31:0];
        gnue_pkg::REG_WHITE_GAIN:     cfg_r.white_gain     <= pwdata[31:0];
        gnue_pkg::REG_DECAY_FACTOR:   cfg_r.decay_factor   <= pwdata[16:0];
        gnue_pkg::REG_NOISE_VARIANCE: cfg_r.noise_variance <= pwdata[31:0];
        gnue_pkg::REG_STATE_SCALE:    cfg_r.state_scale    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gnue_pkg::REG_INIT_STATE:     prdata = cfg_r.init_state;
      gnue_pkg::REG_INIT_SEQ:       prdata = cfg_r.init_seq;
      gnue_pkg::REG_MEAN_LEVEL:     prdata = {32'd0, cfg_r.mean_level};
      gnue_pkg::REG_WHITE_GAIN:     prdata = {32'd0, cfg_r.white_gain};
      gnue_pkg::REG_DECAY_FACTOR:   prdata = {47'd0, cfg_r.decay_factor};
      gnue_pkg::REG_NOISE_VARIANCE: prdata = {32'd0, cfg_r.noise_variance};
      gnue_pkg::REG_STATE_SCALE:    prdata = {32'd0, cfg_r.state_scale};
      default:                      prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/gnue_core.sv @@
// Sequencer and datapath: generator, log, square root, CORDIC and update steps.
`timescale 1ns / 1ps

module gnue_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  gnue_pkg::in_item_t   in_data,
  output logic                 idle,
  input  gnue_pkg::cfg_t       cfg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output gnue_pkg::out_item_t  res_data
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_PCG  = 15'h0002,
    S_RSD  = 15'h0004,
    S_DRAW = 15'h0008,
    S_LOG0 = 15'h0010,
    S_LOGI = 15'h0020,
    S_LN   = 15'h0040,
    S_SQRT = 15'h0080,
    S_ZMUL = 15'h0100,
    S_CORD = 15'h0200,
    S_MAG  = 15'h0400,
    S_AP1  = 15'h0800,
    S_AP2  = 15'h1000,
    S_AP3  = 15'h2000,
    S_FIN  = 15'h4000
  } state_t;

  // Control state.
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic        ph_r, ph_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] gen_state_r, gen_state_nxt;
  logic [63:0] inc_r, inc_nxt;
  logic        spare_valid_r, spare_valid_nxt;

  // Payload state.
  logic [2:0]         act_r, act_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] st_r, st_nxt;
  logic               last_r, last_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [31:0]        rnd_r, rnd_nxt;
  logic [31:0]        r1_r, r1_nxt;
  logic signed [20:0] spare_r, spare_nxt;
  logic signed [20:0] n_r, n_nxt;
  logic [4:0]         p_r, p_nxt;
  logic [31:0]        xl_r, xl_nxt;
  logic [23:0]        f_r, f_nxt;
  logic [29:0]        t_r, t_nxt;
  logic [39:0]        sv_r, sv_nxt;
  logic [39:0]        res_r, res_nxt;
  logic [39:0]        bit_r, bit_nxt;
  logic [19:0]        mag_r, mag_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic signed [47:0] sacc_r, sacc_nxt;
  logic signed [31:0] so_r, so_nxt;

  // Shared multiplier.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  // Helpers.
  logic [4:0]         lz_p;
  logic [31:0]        x_init;
  logic [32:0]        sq;
  logic [23:0]        f_new;
  logic [31:0]        xl_new;
  logic [39:0]        trial;
  logic [39:0]        res_new;
  logic signed [33:0] ang, dx, dy, cs, sn;
  logic signed [47:0] sh;
  logic signed [47:0] val48, mean48;
  logic signed [31:0] mean_s, wg_s, nv_s, os_s;
  logic               need_draw;

  gnue_mult u_mult (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_p)
  );

  assign mean_s = cfg.mean_level;
  assign wg_s   = cfg.white_gain;
  assign nv_s   = cfg.noise_variance;
  assign os_s   = cfg.state_scale;
  assign val48  = 48'(val_r);
  assign mean48 = 48'(mean_s);
  assign sh     = mul_p[63:16];
  assign sq     = mul_p[63:31];
  assign idle   = (state_r == S_IDLE);

  always_comb begin
    lz_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (r1_r[i]) begin
        lz_p = 5'(i);
      end
    end
  end

  assign x_init  = r1_r << (5'd31 - lz_p);
  assign f_new   = {f_r[22:0], sq[32]};
  assign xl_new  = sq[32] ? sq[32:1] : sq[31:0];
  assign trial   = res_r + bit_r;
  assign res_new = (sv_r >= trial) ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign ang     = gnue_pkg::atan_q30(cnt_r);
  assign dx      = cy_r >>> cnt_r;
  assign dy      = cx_r >>> cnt_r;

  always_comb begin
    unique case (rnd_r[31:30])
      2'd0: begin cs = cx_r;  sn = cy_r;  end
      2'd1: begin cs = -cy_r; sn = cx_r;  end
      2'd2: begin cs = -cx_r; sn = -cy_r; end
      2'd3: begin cs = cy_r;  sn = -cx_r; end
    endcase
  end

  // Item actions that consume a normal sample.
  assign need_draw = (in_data.action == gnue_pkg::ACT_NORMAL) ||
                     (in_data.action == gnue_pkg::ACT_WHITE) ||
                     (in_data.action == gnue_pkg::ACT_TEMPORAL) ||
                     ((in_data.action == gnue_pkg::ACT_REVERT) && (nv_s != 32'sd0));

  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    ph_nxt          = ph_r;
    cnt_nxt         = cnt_r;
    gen_state_nxt   = gen_state_r;
    inc_nxt         = inc_r;
    spare_valid_nxt = spare_valid_r;
    act_nxt         = act_r;
    val_nxt         = val_r;
    st_nxt          = st_r;
    last_nxt        = last_r;
    acc_nxt         = acc_r;
    rnd_nxt         = rnd_r;
    r1_nxt          = r1_r;
    spare_nxt       = spare_r;
    n_nxt           = n_r;
    p_nxt           = p_r;
    xl_nxt          = xl_r;
    f_nxt           = f_r;
    t_nxt           = t_r;
    sv_nxt          = sv_r;
    res_nxt         = res_r;
    bit_nxt         = bit_r;
    mag_nxt         = mag_r;
    cx_nxt          = cx_r;
    cy_nxt          = cy_r;
    cz_nxt          = cz_r;
    sacc_nxt        = sacc_r;
    so_nxt          = so_r;
    mul_a           = '0;
    mul_b           = '0;
    res_valid       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_data.action;
          val_nxt  = in_data.value_in;
          st_nxt   = in_data.state_in;
          last_nxt = in_data.last_in;
          cnt_nxt  = '0;
          ph_nxt   = 1'b0;
          if (in_data.action == gnue_pkg::ACT_RESEED) begin
            gen_state_nxt   = '0;
            inc_nxt         = {cfg.init_seq[62:0], 1'b1};
            spare_valid_nxt = 1'b0;
            spare_nxt       = '0;
            state_nxt       = S_PCG;
            ret_nxt         = S_RSD;
          end else if (in_data.action == gnue_pkg::ACT_UNIFORM) begin
            state_nxt = S_PCG;
            ret_nxt   = S_FIN;
          end else if (need_draw) begin
            if (spare_valid_r) begin
              n_nxt           = spare_r;
              spare_valid_nxt = 1'b0;
              state_nxt = (in_data.action == gnue_pkg::ACT_NORMAL) ? S_FIN : S_AP1;
            end else begin
              state_nxt = S_PCG;
              ret_nxt   = S_DRAW;
            end
          end else if (in_data.action == gnue_pkg::ACT_REVERT) begin
            state_nxt = S_AP1;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      // Generator step: low 64 bits of state * multiplier from three partial products.
      S_PCG: begin
        unique case (cnt_r[1:0])
          2'd0: begin
            rnd_nxt = gnue_pkg::pcg_out(gen_state_r);
            mul_a   = signed'({2'b00, gen_state_r[31:0]});
            mul_b   = signed'({2'b00, gnue_pkg::PCG_MULT[31:0]});
            cnt_nxt = 5'd1;
          end
          2'd1: begin
            acc_nxt = mul_p[63:0] + inc_r;
            mul_a   = signed'({2'b00, gen_state_r[31:0]});
            mul_b   = signed'({2'b00, gnue_pkg::PCG_MULT[63:32]});
            cnt_nxt = 5'd2;
          end
          2'd2: begin
            acc_nxt = acc_r + {mul_p[31:0], 32'd0};
            mul_a   = signed'({2'b00, gen_state_r[63:32]});
            mul_b   = signed'({2'b00, gnue_pkg::PCG_MULT[31:0]});
            cnt_nxt = 5'd3;
          end
          2'd3: begin
            gen_state_nxt = acc_r + {mul_p[31:0], 32'd0};
            cnt_nxt       = '0;
            ph_nxt        = 1'b0;
            state_nxt     = ret_r;
          end
        endcase
      end

      S_RSD: begin
        gen_state_nxt = gen_state_r + cfg.init_state;
        state_nxt     = S_PCG;
        ret_nxt       = S_FIN;
      end

      S_DRAW: begin
        r1_nxt    = rnd_r;
        state_nxt = S_PCG;
        ret_nxt   = S_LOG0;
      end

      S_LOG0: begin
        ph_nxt  = 1'b0;
        cnt_nxt = '0;
        if (r1_r == 32'd0) begin
          t_nxt     = gnue_pkg::T_CLAMP;
          state_nxt = S_LN;
        end else begin
          p_nxt     = lz_p;
          xl_nxt    = x_init;
          f_nxt     = '0;
          state_nxt = S_LOGI;
        end
      end

      // One fraction bit of log2 per squaring.
      S_LOGI: begin
        if (!ph_r) begin
          mul_a  = signed'({2'b00, xl_r});
          mul_b  = signed'({2'b00, xl_r});
          ph_nxt = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          f_nxt   = f_new;
          xl_nxt  = xl_new;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'(gnue_pkg::LOG_STEPS - 1)) begin
            t_nxt     = {6'd32 - {1'b0, p_r}, 24'd0} - {6'd0, f_new};
            cnt_nxt   = '0;
            state_nxt = S_LN;
          end
        end
      end

      S_LN: begin
        if (!ph_r) begin
          mul_a  = signed'({4'd0, t_r});
          mul_b  = signed'({2'b00, gnue_pkg::LN2_Q32});
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          sv_nxt    = {1'b0, mul_p[61:31], 8'd0};
          res_nxt   = '0;
          bit_nxt   = 40'd1 << 38;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end

      // Restoring square root, two radicand bits per step.
      S_SQRT: begin
        if (sv_r >= trial) begin
          sv_nxt = sv_r - trial;
        end
        res_nxt = res_new;
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(gnue_pkg::SQRT_STEPS - 1)) begin
          mag_nxt   = res_new[19:0];
          cnt_nxt   = '0;
          ph_nxt    = 1'b0;
          state_nxt = S_ZMUL;
        end
      end

      S_ZMUL: begin
        if (!ph_r) begin
          mul_a  = signed'({4'd0, rnd_r[29:0]});
          mul_b  = signed'({2'b00, gnue_pkg::HALFPI_Q30});
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          cz_nxt    = signed'({2'b00, mul_p[61:30]});
          cx_nxt    = gnue_pkg::CORDIC_K_Q30;
          cy_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_CORD;
        end
      end

      S_CORD: begin
        if (!cz_r[33]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - ang;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + ang;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(gnue_pkg::CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          ph_nxt    = 1'b0;
          state_nxt = S_MAG;
        end
      end

      // Cosine product gives the sample, sine product the spare.
      S_MAG: begin
        if (!ph_r) begin
          mul_a  = signed'({14'd0, mag_r});
          mul_b  = cnt_r[0] ? sn : cs;
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (!cnt_r[0]) begin
            n_nxt   = gnue_pkg::clamp21(mul_p[67:30]);
            cnt_nxt = 5'd1;
          end else begin
            spare_nxt       = gnue_pkg::clamp21(mul_p[67:30]);
            spare_valid_nxt = 1'b1;
            cnt_nxt         = '0;
            state_nxt = (act_r == gnue_pkg::ACT_NORMAL) ? S_FIN : S_AP1;
          end
        end
      end

      S_AP1: begin
        if (!ph_r) begin
          unique case (act_r)
            gnue_pkg::ACT_WHITE: begin
              mul_a = 34'(wg_s);
              mul_b = 34'(n_r);
            end
            gnue_pkg::ACT_TEMPORAL: begin
              mul_a = signed'({17'd0, cfg.decay_factor});
              mul_b = 34'(st_r);
            end
            default: begin
              mul_a = signed'({17'd0, cfg.decay_factor});
              mul_b = 34'(val_r) - 34'(mean_s);
            end
          endcase
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          unique case (act_r)
            gnue_pkg::ACT_WHITE: begin
              sacc_nxt  = val48 + mean48 + sh;
              state_nxt = S_FIN;
            end
            gnue_pkg::ACT_TEMPORAL: begin
              sacc_nxt  = sh;
              state_nxt = S_AP2;
            end
            default: begin
              sacc_nxt  = mean48 + sh;
              state_nxt = (nv_s != 32'sd0) ? S_AP2 : S_FIN;
            end
          endcase
        end
      end

      S_AP2: begin
        if (!ph_r) begin
          mul_a  = 34'(nv_s);
          mul_b  = 34'(n_r);
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (act_r == gnue_pkg::ACT_TEMPORAL) begin
            so_nxt    = gnue_pkg::sat32(sacc_r + sh);
            state_nxt = S_AP3;
          end else begin
            sacc_nxt  = sacc_r + sh;
            state_nxt = S_FIN;
          end
        end
      end

      S_AP3: begin
        if (!ph_r) begin
          mul_a  = 34'(os_s);
          mul_b  = 34'(so_r);
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          sacc_nxt  = val48 + sh;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data.value_out   = '0;
    res_data.state_out   = '0;
    res_data.uniform_raw = '0;
    res_data.last_out    = last_r;
    unique case (act_r)
      gnue_pkg::ACT_UNIFORM:  res_data.uniform_raw = rnd_r;
      gnue_pkg::ACT_NORMAL:   res_data.value_out   = 32'(n_r);
      gnue_pkg::ACT_WHITE:    res_data.value_out   = gnue_pkg::sat32(sacc_r);
      gnue_pkg::ACT_TEMPORAL: begin
        res_data.value_out = gnue_pkg::sat32(sacc_r);
        res_data.state_out = so_r;
      end
      gnue_pkg::ACT_REVERT:   res_data.value_out   = gnue_pkg::sat32(sacc_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ret_r         <= S_IDLE;
      ph_r          <= 1'b0;
      cnt_r         <= '0;
      gen_state_r   <= '0;
      inc_r         <= 64'd1;
      spare_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ret_r         <= ret_nxt;
      ph_r          <= ph_nxt;
      cnt_r         <= cnt_nxt;
      gen_state_r   <= gen_state_nxt;
      inc_r         <= inc_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    val_r   <= val_nxt;
    st_r    <= st_nxt;
    last_r  <= last_nxt;
    acc_r   <= acc_nxt;
    rnd_r   <= rnd_nxt;
    r1_r    <= r1_nxt;
    spare_r <= spare_nxt;
    n_r     <= n_nxt;
    p_r     <= p_nxt;
    xl_r    <= xl_nxt;
    f_r     <= f_nxt;
    t_r     <= t_nxt;
    sv_r    <= sv_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    mag_r   <= mag_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    sacc_r  <= sacc_nxt;
    so_r    <= so_nxt;
  end

endmodule

@@ hw/rtl/gaussian_noise_update_engine_core.sv @@
// Top level of the Gaussian noise update engine: register file, core and output register.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+----------------------------------
//  in_      | input     | in_valid / in_stall    | in_data  (action, value, state, last)
//  out_     | output    | out_valid / out_stall  | out_data (value, state, raw, last)
//  APB      | input     | psel/penable/pready    | paddr, pwdata, prdata (64 bits)
//
// Each item runs on one shared 34 x 34 multiplier under a sequencer; in_stall is high
// from acceptance until the result moves into the output register.
// An item may also be served from the cached spare sample. A fresh normal pair takes two
// generator steps, 24 squaring passes for the log, 20 square-root steps, 30 CORDIC
// rotations and two scaling products. The update arithmetic adds up to three more
// multiplier passes. Reset is synchronous and active low; it restores the generator,
// drops the spare sample and sets the registers to their reset values. A stalled
// result waits in the output register and the next item is accepted meanwhile.

module gaussian_noise_update_engine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gnue_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gnue_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  gnue_pkg::cfg_t      cfg;
  gnue_pkg::out_item_t res_data;
  gnue_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  logic                core_idle;
  logic                res_valid;
  logic                res_ready;

  gnue_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gnue_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .idle      (core_idle),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // The core hands over its result once the output register is empty or draining.
  assign res_ready = !out_valid_r || !out_stall;
  assign in_stall  = !core_idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

`ifndef SYNTH
  // An accepted item keeps the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A result handed over by the core shows up on the output channel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid)
    else $error("core result lost");

  // A taken output with no new result behind it empties the register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(res_valid && res_ready)) |=> !out_valid)
    else $error("result item repeated");

  // The core never offers a result while it is ready for input.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_stall)
    else $error("result offered while idle");
`endif

endmodule

@@ bench/gaussian_noise_update_engine_core_tb.sv @@
// Self-checking testbench of the Gaussian noise update engine core.
`timescale 1ns / 1ps

module gaussian_noise_update_engine_core_tb;

  localparam int STALL_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  gnue_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  gnue_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [5:0]          paddr = '0;
  logic [63:0]         pwdata = '0;
  logic [63:0]         prdata;
  logic                pready;

  always #1 clk = ~clk;

  gaussian_noise_update_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the engine's generator, spare sample and register settings.
  logic [63:0]        pcg_state;
  logic [63:0]        pcg_inc;
  logic               spare_ok;
  logic signed [63:0] spare_val;
  logic [63:0]        r_init_state;
  logic [63:0]        r_init_seq;
  logic signed [63:0] r_mean;
  logic signed [63:0] r_gain;
  logic signed [63:0] r_decay;
  logic signed [63:0] r_var;
  logic signed [63:0] r_scale;

  gnue_pkg::out_item_t expected_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic logic [31:0] pcg_step();
    logic [63:0] old;
    logic [31:0] xs;
    logic [4:0]  rot;
    old = pcg_state;
    pcg_state = old * 64'd6364136223846793005 + (pcg_inc | 64'd1);
    xs = 32'(((old >> 18) ^ old) >> 27);
    rot = old[63:59];
    return (xs >> rot) | (xs << ((32 - rot) & 31));
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // -log2(r / 2^32) in Q8.24 by repeated squaring of the mantissa.
  function automatic logic [63:0] neg_log2(logic [31:0] r);
    int          p;
    logic [63:0] x;
    logic [63:0] f;
    if (r == 0) return 64'd668792462;
    p = 31;
    f = 0;
    while (r[p] == 1'b0) p--;
    x = 64'(r) << (31 - p);
    for (int i = 0; i < 24; i++) begin
      x = (x * x) >> 31;
      f <<= 1;
      if (x >= 64'h1_0000_0000) begin
        f |= 1;
        x >>= 1;
      end
    end
    return (64'(32 - p) << 24) - f;
  endfunction

  function automatic logic signed [63:0] clip21(logic signed [63:0] v);
    if (v > 64'sd1048575) return 64'sd1048575;
    if (v < -64'sd1048576) return -64'sd1048576;
    return v;
  endfunction

  function automatic logic signed [63:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Box-Muller sample; the second of each pair is kept as the spare.
  function automatic logic signed [63:0] gauss_sample();
    logic [31:0]        r1;
    logic [31:0]        r2;
    logic [63:0]        t;
    logic [63:0]        v;
    logic signed [63:0] mag, x, y, z, a, dx, dy, cs, sn;
    if (spare_ok) begin
      spare_ok = 1'b0;
      return spare_val;
    end
    r1 = pcg_step();
    r2 = pcg_step();
    t = neg_log2(r1);
    v = (t * 64'd2977044472) >> 31;
    mag = $signed(int_sqrt(v << 8));
    z = $signed((64'(r2[29:0]) * 64'd1686629713) >> 30);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      a = 64'(gnue_pkg::atan_q30(5'(i)));
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    case (r2[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    spare_val = clip21((mag * sn) >>> 30);
    spare_ok = 1'b1;
    return clip21((mag * cs) >>> 30);
  endfunction

  function automatic gnue_pkg::out_item_t engine_result(gnue_pkg::in_item_t it);
    gnue_pkg::out_item_t o;
    logic signed [63:0]  val, st, vo, so, n;
    o = '0;
    val = 64'(it.value_in);
    st = 64'(it.state_in);
    vo = 0;
    so = 0;
    case (it.action)
      gnue_pkg::ACT_RESEED: begin
        pcg_state = 0;
        pcg_inc = (r_init_seq << 1) | 64'd1;
        spare_ok = 1'b0;
        spare_val = 0;
        void'(pcg_step());
        pcg_state += r_init_state;
        void'(pcg_step());
      end
      gnue_pkg::ACT_UNIFORM: o.uniform_raw = pcg_step();
      gnue_pkg::ACT_NORMAL: vo = gauss_sample();
      gnue_pkg::ACT_WHITE: begin
        n = gauss_sample();
        vo = clip32(val + r_mean + ((r_gain * n) >>> 16));
      end
      gnue_pkg::ACT_TEMPORAL: begin
        n = gauss_sample();
        so = clip32(((r_decay * st) >>> 16) + ((r_var * n) >>> 16));
        vo = clip32(val + ((r_scale * so) >>> 16));
      end
      gnue_pkg::ACT_REVERT: begin
        vo = r_mean + ((r_decay * (val - r_mean)) >>> 16);
        if (r_var != 0) vo += (r_var * gauss_sample()) >>> 16;
        vo = clip32(vo);
      end
      default: ;
    endcase
    o.value_out = vo[31:0];
    o.state_out = so[31:0];
    o.last_out = it.last_in;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      gnue_pkg::REG_INIT_STATE: r_init_state = data;
      gnue_pkg::REG_INIT_SEQ: r_init_seq = data;
      gnue_pkg::REG_MEAN_LEVEL: r_mean = 64'($signed(data[31:0]));
      gnue_pkg::REG_WHITE_GAIN: r_gain = 64'($signed(data[31:0]));
      gnue_pkg::REG_DECAY_FACTOR: r_decay = 64'(data[16:0]);
      gnue_pkg::REG_NOISE_VARIANCE: r_var = 64'($signed(data[31:0]));
      gnue_pkg::REG_STATE_SCALE: r_scale = 64'($signed(data[31:0]));
      default: ;
    endcase
  endtask

  // Sends one item with an optional idle gap before it and records what it must yield.
  task automatic send_item(logic [2:0] act, logic [31:0] val, logic [31:0] st, logic lst);
    gnue_pkg::in_item_t it;
    it.action = act;
    it.value_in = val;
    it.state_in = st;
    it.last_in = lst;
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(engine_result(it));
    in_valid <= 1'b0;
  endtask

  // Drains all pending results, then lets the engine settle before register writes.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_values();
    for (int a = 0; a < 8; a++) send_item(3'(a), 32'h0001_0000, 32'hFFFF_0000, a[0]);
    drain();
  endtask

  task automatic test_directed_corners();
    write_reg(gnue_pkg::REG_INIT_STATE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(gnue_pkg::REG_INIT_SEQ, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(gnue_pkg::REG_MEAN_LEVEL, 64'h7FFF_FFFF);
    write_reg(gnue_pkg::REG_WHITE_GAIN, 64'h8000_0000);
    write_reg(gnue_pkg::REG_DECAY_FACTOR, 64'h1_FFFF);
    write_reg(gnue_pkg::REG_NOISE_VARIANCE, 64'h7FFF_FFFF);
    write_reg(gnue_pkg::REG_STATE_SCALE, 64'h8000_0000);
    send_item(gnue_pkg::ACT_RESEED, 0, 0, 1'b0);
    send_item(gnue_pkg::ACT_UNIFORM, 0, 0, 1'b1);
    send_item(gnue_pkg::ACT_WHITE, 32'h7FFF_FFFF, 0, 1'b0);
    send_item(gnue_pkg::ACT_WHITE, 32'h8000_0000, 0, 1'b0);
    send_item(gnue_pkg::ACT_TEMPORAL, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(gnue_pkg::ACT_TEMPORAL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_item(gnue_pkg::ACT_REVERT, 32'h8000_0000, 0, 1'b0);
    send_item(gnue_pkg::ACT_REVERT, 32'h7FFF_FFFF, 0, 1'b1);
    drain();
    // A zero noise variance skips the draw in the reverting step.
    write_reg(gnue_pkg::REG_NOISE_VARIANCE, 64'h0);
    write_reg(gnue_pkg::REG_DECAY_FACTOR, 64'h0);
    send_item(gnue_pkg::ACT_REVERT, 32'h1234_5678, 0, 1'b0);
    send_item(gnue_pkg::ACT_NORMAL, 0, 0, 1'b0);
    drain();
    // Seed zero state on stream zero, searching for a zero draw is impractical; the
    // clamp is also exercised whenever the random part hits it.
    write_reg(gnue_pkg::REG_INIT_STATE, 64'h0);
    write_reg(gnue_pkg::REG_INIT_SEQ, 64'h0);
    send_item(gnue_pkg::ACT_RESEED, 0, 0, 1'b0);
    for (int i = 0; i < 6; i++) send_item(gnue_pkg::ACT_NORMAL, 0, 0, i[0]);
    drain();
  endtask

  task automatic test_random_phase(int count);
    logic [2:0] act;
    write_reg(gnue_pkg::REG_INIT_STATE, {$urandom, $urandom});
    write_reg(gnue_pkg::REG_INIT_SEQ, {$urandom, $urandom});
    write_reg(gnue_pkg::REG_MEAN_LEVEL, 64'(edge_word()));
    write_reg(gnue_pkg::REG_WHITE_GAIN, 64'(edge_word()));
    write_reg(gnue_pkg::REG_DECAY_FACTOR,
              64'($urandom_range(3) == 0 ? $urandom_range(131071)
                                         : $urandom_range(65536)));
    write_reg(gnue_pkg::REG_NOISE_VARIANCE,
              64'($urandom_range(3) == 0 ? 32'h0 : edge_word()));
    write_reg(gnue_pkg::REG_STATE_SCALE, 64'(edge_word()));
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(49) == 0) ? gnue_pkg::ACT_RESEED : 3'($urandom_range(1, 7));
      send_item(act, edge_word(), edge_word(), 1'($urandom));
    end
    drain();
  endtask

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    gnue_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.value_out !== want.value_out) begin
          $error("value_out expected %h actual %h", want.value_out, out_data.value_out);
          errors++;
        end
        if (out_data.state_out !== want.state_out) begin
          $error("state_out expected %h actual %h", want.state_out, out_data.state_out);
          errors++;
        end
        if (out_data.uniform_raw !== want.uniform_raw) begin
          $error("uniform_raw expected %h actual %h", want.uniform_raw,
                 out_data.uniform_raw);
          errors++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out expected %b actual %b", want.last_out, out_data.last_out);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles in which neither channel nor the register port moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else if (expected_q.size() != 0 || in_valid) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    pcg_state = 0; pcg_inc = 1; spare_ok = 0; spare_val = 0;
    r_init_state = 0; r_init_seq = 0; r_mean = 0; r_gain = 0;
    r_decay = 65536; r_var = 0; r_scale = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_values();
    test_directed_corners();
    send_idle_pct = 23; recv_idle_pct = 54;
    for (int p = 0; p < 3; p++) test_random_phase(200);
    send_idle_pct = 54; recv_idle_pct = 23;
    for (int p = 0; p < 3; p++) test_random_phase(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int p = 0; p < 3; p++) test_random_phase(200);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
